>>> rtl/fcl_pkg.sv
// Shared types, codes and default sizes of the dense layer block.
package fcl_pkg;

   localparam int DEF_MAX_INPUTS  = 64;
   localparam int DEF_MAX_OUTPUTS = 64;
   localparam int DEF_MAX_BATCH   = 16;
   localparam int DEF_DATA_WIDTH  = 16;
   localparam int QUEUE_DEPTH     = 4;
   localparam int RES_DEPTH       = 4;
   localparam int POS_LIMIT       = 64;

   // command codes on req_tuser
   localparam logic [3:0] CMD_WR_W   = 4'd0;
   localparam logic [3:0] CMD_WR_B   = 4'd1;
   localparam logic [3:0] CMD_FWD    = 4'd2;
   localparam logic [3:0] CMD_BWD    = 4'd3;
   localparam logic [3:0] CMD_ADD_W  = 4'd4;
   localparam logic [3:0] CMD_ADD_B  = 4'd5;
   localparam logic [3:0] CMD_RD_W   = 4'd6;
   localparam logic [3:0] CMD_RD_B   = 4'd7;
   localparam logic [3:0] CMD_RD_DW  = 4'd8;
   localparam logic [3:0] CMD_RD_DB  = 4'd9;
   localparam logic [3:0] CMD_ZERO   = 4'd10;
   localparam logic [3:0] CMD_CLEAR  = 4'd11;

   // classified operations handed from front to back
   localparam logic [3:0] OP_ACK     = 4'd0;
   localparam logic [3:0] OP_WR_W    = 4'd1;
   localparam logic [3:0] OP_WR_B    = 4'd2;
   localparam logic [3:0] OP_FWD     = 4'd3;
   localparam logic [3:0] OP_BWD     = 4'd4;
   localparam logic [3:0] OP_ADD_W   = 4'd5;
   localparam logic [3:0] OP_ADD_B   = 4'd6;
   localparam logic [3:0] OP_RD_W    = 4'd7;
   localparam logic [3:0] OP_RD_B    = 4'd8;
   localparam logic [3:0] OP_RD_DW   = 4'd9;
   localparam logic [3:0] OP_RD_DB   = 4'd10;
   localparam logic [3:0] OP_ZERO    = 4'd11;

   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_NO_CACHE = 2'd1;
   localparam logic [1:0] ST_BAD_IDX  = 2'd2;

   localparam logic REG_INPUT_COUNT  = 1'b0;
   localparam logic REG_OUTPUT_COUNT = 1'b1;

   typedef struct packed {
      logic [3:0]  kind;
      logic [1:0]  status;
      logic [3:0]  row;
      logic [5:0]  out_pos;
      logic [5:0]  in_pos;
      logic [15:0] value;
      logic        row_end;
   } op_type;

   typedef struct packed {
      logic [1:0]  status;
      logic        last;
      logic [5:0]  pos;
      logic [31:0] value;
   } res_type;

endpackage

>>> rtl/fcl_ram.sv
// Generic single-write, single-read RAM with registered read data.
module fcl_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 64
) (
   input  logic                                clock,
   input  logic                                we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                    wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                    rdata
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata <= mem[raddr];
   end
endmodule

>>> rtl/fcl_fifo.sv
// Small register FIFO used for the op queue and the result buffer.
module fcl_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         in_valid,
   output logic                         in_ready,
   input  logic [WIDTH-1:0]             in_data,
   output logic                         out_valid,
   input  logic                         out_ready,
   output logic [WIDTH-1:0]             out_data,
   output logic [$clog2(DEPTH+1)-1:0]   count
);
   localparam int PW = DEPTH > 1 ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH+1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wptr_ff, wptr_in, rptr_ff, rptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             wr, rd;

   assign in_ready  = count_ff < CW'(DEPTH);
   assign out_valid = count_ff != '0;
   assign out_data  = mem_ff[rptr_ff];
   assign count     = count_ff;
   assign wr        = in_valid && in_ready;
   assign rd        = out_valid && out_ready;

   always_comb begin
      wptr_in  = wptr_ff;
      rptr_in  = rptr_ff;
      count_in = count_ff;
      if (wr) begin
         wptr_in = (wptr_ff == PW'(DEPTH-1)) ? '0 : wptr_ff + PW'(1);
      end
      if (rd) begin
         rptr_in = (rptr_ff == PW'(DEPTH-1)) ? '0 : rptr_ff + PW'(1);
      end
      if (wr && !rd) begin
         count_in = count_ff + CW'(1);
      end else if (rd && !wr) begin
         count_in = count_ff - CW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wptr_ff  <= '0;
         rptr_ff  <= '0;
         count_ff <= '0;
      end else begin
         wptr_ff  <= wptr_in;
         rptr_ff  <= rptr_in;
         count_ff <= count_in;
      end
      if (wr) begin
         mem_ff[wptr_ff] <= in_data;
      end
   end
endmodule

>>> rtl/fcl_front.sv
// Front end: accepts request beats, checks indexes and cache state, emits ops.
module fcl_front #(
   parameter int MAX_BATCH = 16
) (
   input  logic            clock,
   input  logic            reset,
   input  logic            req_tvalid,
   output logic            req_tready,
   input  logic [31:0]     req_tdata,
   input  logic [3:0]      req_tuser,
   input  logic            req_tlast,
   input  logic [6:0]      n_in,
   input  logic [6:0]      n_out,
   output logic            op_valid,
   input  logic            op_ready,
   output fcl_pkg::op_type op
);
   import fcl_pkg::*;

   logic       cache_ff, cache_in;
   logic [3:0] row;
   logic [5:0] o_pos, i_pos;
   logic       b_ok, i_ok, w_ok, row_ok, accept;
   logic       cp_set, cp_clr;
   logic [3:0] kind;
   logic [1:0] status;

   assign row    = req_tdata[3:0];
   assign o_pos  = req_tdata[9:4];
   assign i_pos  = req_tdata[15:10];
   assign b_ok   = {1'b0, o_pos} < n_out;
   assign i_ok   = {1'b0, i_pos} < n_in;
   assign w_ok   = b_ok && i_ok;
   assign row_ok = int'(row) < MAX_BATCH;

   always_comb begin
      kind   = OP_ACK;
      status = ST_OK;
      cp_set = 1'b0;
      cp_clr = 1'b0;
      unique case (req_tuser)
         CMD_WR_W:  if (w_ok) kind = OP_WR_W; else status = ST_BAD_IDX;
         CMD_WR_B:  if (b_ok) kind = OP_WR_B; else status = ST_BAD_IDX;
         CMD_FWD: begin
            if (i_ok && row_ok) begin
               kind   = OP_FWD;
               cp_set = req_tlast;
            end else begin
               status = ST_BAD_IDX;
            end
         end
         CMD_BWD: begin
            if (!cache_ff) status = ST_NO_CACHE;
            else if (b_ok && row_ok) kind = OP_BWD;
            else status = ST_BAD_IDX;
         end
         CMD_ADD_W: if (w_ok) kind = OP_ADD_W; else status = ST_BAD_IDX;
         CMD_ADD_B: if (b_ok) kind = OP_ADD_B; else status = ST_BAD_IDX;
         CMD_RD_W:  if (w_ok) kind = OP_RD_W; else status = ST_BAD_IDX;
         CMD_RD_B:  if (b_ok) kind = OP_RD_B; else status = ST_BAD_IDX;
         CMD_RD_DW: begin
            if (!cache_ff) status = ST_NO_CACHE;
            else if (w_ok) kind = OP_RD_DW;
            else status = ST_BAD_IDX;
         end
         CMD_RD_DB: begin
            if (!cache_ff) status = ST_NO_CACHE;
            else if (b_ok) kind = OP_RD_DB;
            else status = ST_BAD_IDX;
         end
         CMD_ZERO:  kind = OP_ZERO;
         CMD_CLEAR: begin
            kind   = OP_ZERO;
            cp_clr = 1'b1;
         end
         default:   status = ST_BAD_IDX;
      endcase
   end

   assign op_valid    = req_tvalid;
   assign req_tready  = op_ready;
   assign accept      = req_tvalid && op_ready;
   assign op.kind     = kind;
   assign op.status   = status;
   assign op.row      = row;
   assign op.out_pos  = o_pos;
   assign op.in_pos   = i_pos;
   assign op.value    = req_tdata[31:16];
   assign op.row_end  = req_tlast;

   always_comb begin
      cache_in = cache_ff;
      if (accept && cp_clr) begin
         cache_in = 1'b0;
      end else if (accept && cp_set) begin
         cache_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cache_ff <= 1'b0;
      end else begin
         cache_ff <= cache_in;
      end
   end
endmodule

>>> rtl/fcl_back.sv
// Back end: sequencer, memories, shared multiply-accumulate and result buffer.
module fcl_back #(
   parameter int MAX_INPUTS  = 64,
   parameter int MAX_OUTPUTS = 64,
   parameter int MAX_BATCH   = 16,
   parameter int DATA_WIDTH  = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic [6:0]       n_in,
   input  logic [6:0]       n_out,
   input  logic             op_valid,
   output logic             op_ready,
   input  fcl_pkg::op_type  op,
   output logic             res_valid,
   input  logic             res_ready,
   output fcl_pkg::res_type res
);
   import fcl_pkg::*;

   localparam int WDEPTH = MAX_OUTPUTS * MAX_INPUTS;
   localparam int XDEPTH = MAX_BATCH * MAX_INPUTS;
   localparam int WA_W   = WDEPTH > 1 ? $clog2(WDEPTH) : 1;
   localparam int XA_W   = XDEPTH > 1 ? $clog2(XDEPTH) : 1;
   localparam int OA_W   = MAX_OUTPUTS > 1 ? $clog2(MAX_OUTPUTS) : 1;
   localparam int OPW    = DATA_WIDTH > 16 ? DATA_WIDTH : 16;
   localparam int PW     = OPW + 16;
   localparam int ACC_W  = PW + 8;
   localparam int SW     = OPW + 1;
   localparam int RC_W   = $clog2(RES_DEPTH + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_SWEEP = 3'd1;
   localparam logic [2:0] S_FWD   = 3'd2;
   localparam logic [2:0] S_GRAD  = 3'd3;
   localparam logic [2:0] S_DX    = 3'd4;

   localparam logic [3:0] K_LIT  = 4'd0;
   localparam logic [3:0] K_RDW  = 4'd1;
   localparam logic [3:0] K_RDB  = 4'd2;
   localparam logic [3:0] K_RDDW = 4'd3;
   localparam logic [3:0] K_RDDB = 4'd4;
   localparam logic [3:0] K_ADDW = 4'd5;
   localparam logic [3:0] K_ADDB = 4'd6;
   localparam logic [3:0] K_FWD  = 4'd7;
   localparam logic [3:0] K_GRAD = 4'd8;
   localparam logic [3:0] K_DX   = 4'd9;

   localparam logic signed [SW-1:0] DMAX = SW'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
   localparam logic signed [SW-1:0] DMIN = -DMAX - SW'(1);

   typedef struct packed {
      logic              valid;
      logic [3:0]        kind;
      logic              emit;
      logic              first;
      logic              row0;
      logic              dbupd;
      logic              last;
      logic [1:0]        status;
      logic [5:0]        pos;
      logic [WA_W-1:0]   waddr;
      logic [OA_W-1:0]   oaddr;
      logic [15:0]       addval;
   } uop_type;

   function automatic logic [DATA_WIDTH-1:0] sat_d(input logic signed [SW-1:0] v);
      logic signed [SW-1:0] r;
      r = v > DMAX ? DMAX : (v < DMIN ? DMIN : v);
      return r[DATA_WIDTH-1:0];
   endfunction

   function automatic logic [31:0] sat32(input logic signed [63:0] v);
      logic [31:0] r;
      if (v > 64'sh7FFF_FFFF) r = 32'h7FFF_FFFF;
      else if (v < -64'sh8000_0000) r = 32'h8000_0000;
      else r = v[31:0];
      return r;
   endfunction

   // sequencer
   logic [2:0]       state_ff, state_in;
   logic             clear_all_ff, clear_all_in;
   logic [WA_W-1:0]  sw_ff, sw_in;
   logic [5:0]       a_ff, a_in, c_ff, c_in;
   logic [3:0]       row_ff, row_in;
   uop_type          ua, ub_ff, uc_ff, ud_ff;

   logic [5:0]       o_sel, i_sel;
   logic [3:0]       row_sel;
   logic [WA_W-1:0]  wa;
   logic [XA_W-1:0]  xa;
   logic [OA_W-1:0]  oa;
   logic             a_last, c_last, pipe_empty, credit_ok, sweeping, sw_low;
   logic             idle_w_we, idle_b_we, x_we, g_we;

   // memory ports
   logic                  w_we, b_we, dw_we, db_we;
   logic [WA_W-1:0]       w_waddr, dw_waddr;
   logic [OA_W-1:0]       b_waddr, db_waddr;
   logic [DATA_WIDTH-1:0] w_wdata, b_wdata, w_rd, b_rd;
   logic [31:0]           dw_wdata, db_wdata, dw_rd, db_rd;
   logic [15:0]           x_rd, g_rd;

   // datapath
   logic signed [OPW-1:0]   w_ext, g_ext, mul_a;
   logic signed [15:0]      mul_b;
   logic signed [PW-1:0]    prod_ff, prod_in, t12;
   logic signed [ACC_W-1:0] init_ff, init_in, acc_ff, acc_in;
   logic signed [ACC_W:0]   rnd_t;
   logic [31:0]             valc_ff, valc_in, vald_ff, vald_in, dbd_ff, dbd_in;
   logic signed [31:0]      dwc_ff, dbc_ff;
   logic signed [15:0]      gc_ff;
   logic signed [32:0]      p12, dw_sum, db_sum;
   logic [WA_W-1:0]         addw_addr;
   logic [DATA_WIDTH-1:0]   addw_val, addb_val;
   logic                    push, res_in_ready, b_is_mac;
   logic [RC_W-1:0]         res_cnt;
   res_type                 res_in;
   int                      inflight;

   assign sweeping   = state_ff == S_SWEEP;
   assign sw_low     = int'(sw_ff) < MAX_OUTPUTS;
   assign o_sel      = (state_ff == S_IDLE) ? op.out_pos : a_ff;
   assign i_sel      = (state_ff == S_IDLE) ? op.in_pos : c_ff;
   assign row_sel    = (state_ff == S_IDLE) ? op.row : row_ff;
   assign wa         = WA_W'(int'(o_sel) * MAX_INPUTS + int'(i_sel));
   assign xa         = XA_W'(int'(row_sel) * MAX_INPUTS + int'(i_sel));
   assign oa         = OA_W'(o_sel);
   assign a_last     = {1'b0, a_ff} == n_out - 7'd1;
   assign c_last     = {1'b0, c_ff} == n_in - 7'd1;
   assign pipe_empty = !(ub_ff.valid || uc_ff.valid || ud_ff.valid);
   assign inflight   = int'(ub_ff.valid && ub_ff.emit) + int'(uc_ff.valid && uc_ff.emit)
                     + int'(ud_ff.valid && ud_ff.emit);
   assign credit_ok  = int'(res_cnt) + inflight < RES_DEPTH;

   always_comb begin
      state_in     = state_ff;
      clear_all_in = clear_all_ff;
      sw_in        = sw_ff;
      a_in         = a_ff;
      c_in         = c_ff;
      row_in       = row_ff;
      op_ready     = 1'b0;
      idle_w_we    = 1'b0;
      idle_b_we    = 1'b0;
      x_we         = 1'b0;
      g_we         = 1'b0;
      ua           = '0;
      ua.waddr     = wa;
      ua.oaddr     = oa;
      ua.addval    = op.value;
      ua.row0      = row_ff == 4'd0;
      ua.last      = 1'b1;
      unique case (state_ff)
         S_IDLE: begin
            if (op_valid && pipe_empty && credit_ok) begin
               op_ready = 1'b1;
               ua.valid = 1'b1;
               ua.emit  = 1'b1;
               ua.kind  = K_LIT;
               unique case (op.kind)
                  OP_ACK:   ua.status = op.status;
                  OP_WR_W:  idle_w_we = 1'b1;
                  OP_WR_B:  idle_b_we = 1'b1;
                  OP_ADD_W: ua.kind = K_ADDW;
                  OP_ADD_B: ua.kind = K_ADDB;
                  OP_RD_W: begin
                     ua.kind = K_RDW;
                     ua.pos  = op.in_pos;
                  end
                  OP_RD_B: begin
                     ua.kind = K_RDB;
                     ua.pos  = op.out_pos;
                  end
                  OP_RD_DW: begin
                     ua.kind = K_RDDW;
                     ua.pos  = op.in_pos;
                  end
                  OP_RD_DB: begin
                     ua.kind = K_RDDB;
                     ua.pos  = op.out_pos;
                  end
                  OP_FWD: begin
                     ua.valid = 1'b0;
                     x_we     = 1'b1;
                     if (op.row_end) begin
                        state_in = S_FWD;
                        a_in     = '0;
                        c_in     = '0;
                        row_in   = op.row;
                     end
                  end
                  OP_BWD: begin
                     ua.valid = 1'b0;
                     g_we     = 1'b1;
                     if (op.row_end) begin
                        state_in = S_GRAD;
                        a_in     = '0;
                        c_in     = '0;
                        row_in   = op.row;
                     end
                  end
                  OP_ZERO: begin
                     state_in     = S_SWEEP;
                     clear_all_in = 1'b0;
                     sw_in        = '0;
                  end
                  default:  ua.status = ST_BAD_IDX;
               endcase
            end
         end
         S_SWEEP: begin
            sw_in = sw_ff + WA_W'(1);
            if (sw_ff == WA_W'(WDEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_FWD: begin
            if (credit_ok) begin
               ua.valid = 1'b1;
               ua.kind  = K_FWD;
               ua.first = c_ff == 6'd0;
               ua.emit  = c_last;
               ua.last  = a_last;
               ua.pos   = a_ff;
               c_in     = c_ff + 6'd1;
               if (c_last) begin
                  c_in = '0;
                  a_in = a_ff + 6'd1;
                  if (a_last) state_in = S_IDLE;
               end
            end
         end
         S_GRAD: begin
            ua.valid = 1'b1;
            ua.kind  = K_GRAD;
            ua.dbupd = c_ff == 6'd0;
            c_in     = c_ff + 6'd1;
            if (c_last) begin
               c_in = '0;
               a_in = a_ff + 6'd1;
               if (a_last) begin
                  a_in     = '0;
                  state_in = S_DX;
               end
            end
         end
         S_DX: begin
            // column outer, output inner
            if (credit_ok) begin
               ua.valid = 1'b1;
               ua.kind  = K_DX;
               ua.first = a_ff == 6'd0;
               ua.emit  = a_last;
               ua.last  = c_last;
               ua.pos   = c_ff;
               a_in     = a_ff + 6'd1;
               if (a_last) begin
                  a_in = '0;
                  c_in = c_ff + 6'd1;
                  if (c_last) state_in = S_IDLE;
               end
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_SWEEP;
         clear_all_ff <= 1'b1;
         sw_ff        <= '0;
         a_ff         <= '0;
         c_ff         <= '0;
         row_ff       <= '0;
         ub_ff        <= '0;
         uc_ff        <= '0;
         ud_ff        <= '0;
      end else begin
         state_ff     <= state_in;
         clear_all_ff <= clear_all_in;
         sw_ff        <= sw_in;
         a_ff         <= a_in;
         c_ff         <= c_in;
         row_ff       <= row_in;
         ub_ff        <= ua;
         uc_ff        <= ub_ff;
         ud_ff        <= uc_ff;
      end
   end

   // read-modify-write of parameters happens in stage B
   assign addw_addr = ub_ff.waddr;
   assign addw_val  = sat_d(SW'($signed(w_rd)) + SW'($signed(ub_ff.addval)));
   assign addb_val  = sat_d(SW'($signed(b_rd)) + SW'($signed(ub_ff.addval)));

   always_comb begin
      w_we    = idle_w_we;
      w_waddr = wa;
      w_wdata = sat_d(SW'($signed(op.value)));
      if (sweeping) begin
         w_we    = clear_all_ff;
         w_waddr = sw_ff;
         w_wdata = '0;
      end else if (ub_ff.valid && ub_ff.kind == K_ADDW) begin
         w_we    = 1'b1;
         w_waddr = addw_addr;
         w_wdata = addw_val;
      end
      b_we    = idle_b_we;
      b_waddr = oa;
      b_wdata = sat_d(SW'($signed(op.value)));
      if (sweeping) begin
         b_we    = clear_all_ff && sw_low;
         b_waddr = OA_W'(sw_ff);
         b_wdata = '0;
      end else if (ub_ff.valid && ub_ff.kind == K_ADDB) begin
         b_we    = 1'b1;
         b_waddr = ub_ff.oaddr;
         b_wdata = addb_val;
      end
      dw_we    = ud_ff.valid && ud_ff.kind == K_GRAD;
      dw_waddr = ud_ff.waddr;
      dw_wdata = vald_ff;
      db_we    = ud_ff.valid && ud_ff.kind == K_GRAD && ud_ff.dbupd;
      db_waddr = ud_ff.oaddr;
      db_wdata = dbd_ff;
      if (sweeping) begin
         dw_we    = 1'b1;
         dw_waddr = sw_ff;
         dw_wdata = '0;
         db_we    = sw_low;
         db_waddr = OA_W'(sw_ff);
         db_wdata = '0;
      end
   end

   fcl_ram #(.WIDTH(DATA_WIDTH), .DEPTH(WDEPTH)) u_w_ram (
      .clock(clock), .we(w_we), .waddr(w_waddr), .wdata(w_wdata), .raddr(wa), .rdata(w_rd));
   fcl_ram #(.WIDTH(DATA_WIDTH), .DEPTH(MAX_OUTPUTS)) u_b_ram (
      .clock(clock), .we(b_we), .waddr(b_waddr), .wdata(b_wdata), .raddr(oa), .rdata(b_rd));
   fcl_ram #(.WIDTH(16), .DEPTH(XDEPTH)) u_x_ram (
      .clock(clock), .we(x_we), .waddr(xa), .wdata(op.value), .raddr(xa), .rdata(x_rd));
   fcl_ram #(.WIDTH(16), .DEPTH(MAX_OUTPUTS)) u_g_ram (
      .clock(clock), .we(g_we), .waddr(oa), .wdata(op.value), .raddr(oa), .rdata(g_rd));
   fcl_ram #(.WIDTH(32), .DEPTH(WDEPTH)) u_dw_ram (
      .clock(clock), .we(dw_we), .waddr(dw_waddr), .wdata(dw_wdata), .raddr(wa),
      .rdata(dw_rd));
   fcl_ram #(.WIDTH(32), .DEPTH(MAX_OUTPUTS)) u_db_ram (
      .clock(clock), .we(db_we), .waddr(db_waddr), .wdata(db_wdata), .raddr(oa),
      .rdata(db_rd));

   // stage B: read data in, multiply
   assign w_ext    = OPW'($signed(w_rd));
   assign g_ext    = OPW'($signed(g_rd));
   assign mul_a    = (ub_ff.kind == K_GRAD) ? g_ext : w_ext;
   assign mul_b    = (ub_ff.kind == K_DX) ? $signed(g_rd) : $signed(x_rd);
   assign prod_in  = mul_a * mul_b;
   assign b_is_mac = ub_ff.kind == K_FWD && ub_ff.first;
   assign init_in  = b_is_mac ? (ACC_W'($signed(b_rd)) <<< 12) : '0;

   always_comb begin
      case (ub_ff.kind)
         K_RDW:   valc_in = 32'($signed(w_rd));
         K_RDB:   valc_in = 32'($signed(b_rd));
         K_RDDW:  valc_in = dw_rd;
         K_RDDB:  valc_in = db_rd;
         default: valc_in = '0;
      endcase
   end

   // stage C: accumulate or gradient update
   assign t12    = prod_ff + PW'(2048);
   assign p12    = 33'(t12 >>> 12);
   assign dw_sum = uc_ff.row0 ? p12 : 33'(dwc_ff) + p12;
   assign db_sum = uc_ff.row0 ? 33'(gc_ff) : 33'(dbc_ff) + 33'(gc_ff);
   assign dbd_in = sat32(64'(db_sum));

   always_comb begin
      acc_in  = acc_ff;
      vald_in = valc_ff;
      if (uc_ff.valid && (uc_ff.kind == K_FWD || uc_ff.kind == K_DX)) begin
         acc_in = (uc_ff.first ? init_ff : acc_ff) + ACC_W'(prod_ff);
      end
      if (uc_ff.kind == K_GRAD) begin
         vald_in = sat32(64'(dw_sum));
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      init_ff <= init_in;
      valc_ff <= valc_in;
      dwc_ff  <= $signed(dw_rd);
      dbc_ff  <= $signed(db_rd);
      gc_ff   <= $signed(g_rd);
      acc_ff  <= acc_in;
      vald_ff <= vald_in;
      dbd_ff  <= dbd_in;
   end

   // stage D: round sums, push results
   assign rnd_t  = (ACC_W+1)'(acc_ff) + (ACC_W+1)'(2048);
   assign push   = ud_ff.valid && ud_ff.emit;
   assign res_in.value  = (ud_ff.kind == K_FWD || ud_ff.kind == K_DX) ?
                          sat32(64'(rnd_t >>> 12)) : vald_ff;
   assign res_in.pos    = ud_ff.pos;
   assign res_in.last   = ud_ff.last;
   assign res_in.status = ud_ff.status;

   fcl_fifo #(.WIDTH($bits(res_type)), .DEPTH(RES_DEPTH)) u_res_fifo (
      .clock(clock), .reset(reset),
      .in_valid(push), .in_ready(res_in_ready), .in_data(res_in),
      .out_valid(res_valid), .out_ready(res_ready), .out_data(res),
      .count(res_cnt));

   a_push_room: assert property (@(posedge clock) disable iff (reset)
      push |-> res_in_ready) else $error("result pushed into full buffer");
   a_credit: assert property (@(posedge clock) disable iff (reset)
      int'(res_cnt) + inflight <= RES_DEPTH) else $error("result credit overrun");
   a_sweep_quiet: assert property (@(posedge clock) disable iff (reset)
      sweeping |-> !(ud_ff.valid && ud_ff.kind == K_GRAD))
      else $error("gradient write during sweep");
   a_add_idle: assert property (@(posedge clock) disable iff (reset)
      (ub_ff.valid && (ub_ff.kind == K_ADDW || ub_ff.kind == K_ADDB)) |-> state_ff == S_IDLE)
      else $error("parameter update outside idle");
endmodule

>>> rtl/dense_layer_forward_backward.sv
// Fully connected layer, Q4.12, forward pass and gradients with one shared MAC.
//
// req channel: one command beat per item (tuser = command, tlast = row end).
// rsp channel: result beats (tuser = status, tlast = last result of a run).
// csr port: APB writes/reads of input_count (0x0) and output_count (0x4).
// Simple commands (writes, adds, reads, acks, errors) give one result each.
// A forward element with row end starts output_count sums of input_count
// products, one product per cycle through a 4-stage MAC pipe while the
// result buffer has room. A backward row end walks n_out*n_in gradient
// updates and then n_out*n_in products for dx. The MAC loop sets the rate;
// the back end takes a new command only when its MAC pipe is empty.
// After reset the block clears weights, biases and gradients in a sweep over
// all MAX_OUTPUTS*MAX_INPUTS weight addresses (4096 by default) before taking
// items; the zero-gradients and clear commands sweep the gradients the same way.
// A 4-entry op queue sits between front and back; a 4-entry result buffer
// holds results while rsp_tready is low, and the MAC pauses when it has no room for more.
module dense_layer_forward_backward
   import fcl_pkg::*;
#(
   parameter int MAX_INPUTS  = DEF_MAX_INPUTS,
   parameter int MAX_OUTPUTS = DEF_MAX_OUTPUTS,
   parameter int MAX_BATCH   = DEF_MAX_BATCH,
   parameter int DATA_WIDTH  = DEF_DATA_WIDTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // batch_row[3:0], out_pos[9:4], in_pos[15:10], value[31:16]
   input  logic [3:0]  req_tuser,   // command[3:0]
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // result_value[31:0], result_pos[37:32], zero[39:38]
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast,
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);
   localparam int IN_LIM  = MAX_INPUTS < POS_LIMIT ? MAX_INPUTS : POS_LIMIT;
   localparam int OUT_LIM = MAX_OUTPUTS < POS_LIMIT ? MAX_OUTPUTS : POS_LIMIT;

   logic [6:0] in_cnt_ff, in_cnt_in, out_cnt_ff, out_cnt_in, n_in, n_out;
   logic       csr_wr;
   op_type     f_op, q_op;
   logic       f_valid, f_ready, q_valid, q_ready;
   res_type    res;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite && csr_pready;
   assign in_cnt_in  = (csr_wr && csr_paddr[2] == REG_INPUT_COUNT) ? csr_pwdata[6:0]
                                                                  : in_cnt_ff;
   assign out_cnt_in = (csr_wr && csr_paddr[2] == REG_OUTPUT_COUNT) ? csr_pwdata[6:0]
                                                                   : out_cnt_ff;
   assign csr_prdata = {25'd0, (csr_paddr[2] == REG_OUTPUT_COUNT) ? out_cnt_ff : in_cnt_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         in_cnt_ff  <= 7'd64;
         out_cnt_ff <= 7'd64;
      end else begin
         in_cnt_ff  <= in_cnt_in;
         out_cnt_ff <= out_cnt_in;
      end
   end

   assign n_in  = (in_cnt_ff == 7'd0) ? 7'd1 : (in_cnt_ff > 7'(IN_LIM) ? 7'(IN_LIM) : in_cnt_ff);
   assign n_out = (out_cnt_ff == 7'd0) ? 7'd1
                : (out_cnt_ff > 7'(OUT_LIM) ? 7'(OUT_LIM) : out_cnt_ff);

   fcl_front #(.MAX_BATCH(MAX_BATCH)) u_front (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .req_tuser(req_tuser), .req_tlast(req_tlast),
      .n_in(n_in), .n_out(n_out),
      .op_valid(f_valid), .op_ready(f_ready), .op(f_op));

   fcl_fifo #(.WIDTH($bits(op_type)), .DEPTH(QUEUE_DEPTH)) u_queue (
      .clock(clock), .reset(reset),
      .in_valid(f_valid), .in_ready(f_ready), .in_data(f_op),
      .out_valid(q_valid), .out_ready(q_ready), .out_data(q_op),
      .count());

   fcl_back #(
      .MAX_INPUTS(MAX_INPUTS), .MAX_OUTPUTS(MAX_OUTPUTS),
      .MAX_BATCH(MAX_BATCH), .DATA_WIDTH(DATA_WIDTH)
   ) u_back (
      .clock(clock), .reset(reset), .n_in(n_in), .n_out(n_out),
      .op_valid(q_valid), .op_ready(q_ready), .op(q_op),
      .res_valid(rsp_tvalid), .res_ready(rsp_tready), .res(res));

   assign rsp_tdata = {2'b00, res.pos, res.value};
   assign rsp_tuser = res.status;
   assign rsp_tlast = res.last;
endmodule

>>> bench/testbench.sv
// Self-checking testbench for the dense layer block: directed and random command streams.
`timescale 1ns/1ps
module testbench;
   import fcl_pkg::*;
   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [3:0] CMD_UNUSED = 4'd15;
   localparam int IDLE_WAIT = 4300;   // covers a full gradient or reset sweep

   typedef struct {
      logic [31:0] value;
      logic [5:0]  pos;
      logic        last;
      logic [1:0]  status;
   } layer_result_t;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;
   logic [3:0]  req_tuser;
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;
   logic        csr_psel;
   logic        csr_penable;
   logic        csr_pwrite;
   logic [2:0]  csr_paddr;
   logic [31:0] csr_pwdata;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   dense_layer_forward_backward DUT (.*);

   // layer state as the bench sees it
   int  weight[64][64];
   int  bias[64];
   int  x_cache[16][64];
   bit  x_written[16][64];
   int  grad_buf[64];
   bit  grad_written[64];
   int  weight_grad[64][64];
   int  bias_grad[64];
   bit  cache_valid;
   logic [6:0] input_count_reg;
   logic [6:0] output_count_reg;

   layer_result_t pending_results[$];
   int  mismatches;
   bit  no_gaps;
   int  hold_cycles;
   int  stall_left;

   initial begin
      forever #10 clock = ~clock;
   end

   initial begin
      #20ms;
      $display("*** FAILED ***");
      $finish;
   end

   function automatic int eff_count(logic [6:0] r);
      if (r < 1) return 1;
      return (r > 64) ? 64 : int'(r);
   endfunction

   function automatic int sat_weight(longint v);
      if (v > 32767) return 32767;
      if (v < -32768) return -32768;
      return int'(v);
   endfunction

   function automatic int sat_word(longint v);
      if (v > 64'sd2147483647) return 32'sh7fffffff;
      if (v < -64'sd2147483648) return 32'sh80000000;
      return int'(v);
   endfunction

   function automatic int round_q12(longint acc);
      longint t;
      t = acc;
      if (t > (64'sd1 <<< 62)) t = 64'sd1 <<< 62;
      if (t < -(64'sd1 <<< 62)) t = -(64'sd1 <<< 62);
      t = t + 2048;
      return sat_word(t >>> 12);
   endfunction

   task automatic expect_result(int v, int pos, bit last, logic [1:0] st);
      layer_result_t r;
      r.value = v;
      r.pos = pos[5:0];
      r.last = last;
      r.status = st;
      pending_results.push_back(r);
   endtask

   // would this element complete a row that can be computed without unwritten data
   function automatic bit row_complete(logic [3:0] cmd, int row, int o, int i);
      int n_in, n_out;
      n_in = eff_count(input_count_reg);
      n_out = eff_count(output_count_reg);
      if (cmd == CMD_FWD) begin
         if (i >= n_in) return 1'b1;
         for (int c = 0; c < n_in; c++) if (c != i && !x_written[row][c]) return 1'b0;
         return 1'b1;
      end
      if (cmd == CMD_BWD) begin
         if (!cache_valid || o >= n_out) return 1'b1;
         for (int a = 0; a < n_out; a++) if (a != o && !grad_written[a]) return 1'b0;
         for (int c = 0; c < n_in; c++) if (!x_written[row][c]) return 1'b0;
      end
      return 1'b1;
   endfunction

   task automatic predict_layer(logic [3:0] cmd, int row, int o, int i, logic [15:0] raw,
                                bit row_end);
      int n_in, n_out, v, g;
      bit b_ok, w_ok;
      longint acc;
      n_in = eff_count(input_count_reg);
      n_out = eff_count(output_count_reg);
      v = $signed(raw);
      b_ok = o < n_out;
      w_ok = b_ok && i < n_in;
      case (cmd)
         CMD_WR_W, CMD_ADD_W: begin
            if (!w_ok) expect_result(0, 0, 1, ST_BAD_IDX);
            else begin
               weight[o][i] = sat_weight((cmd == CMD_ADD_W ? longint'(weight[o][i]) : 0) + v);
               expect_result(0, 0, 1, ST_OK);
            end
         end
         CMD_WR_B, CMD_ADD_B: begin
            if (!b_ok) expect_result(0, 0, 1, ST_BAD_IDX);
            else begin
               bias[o] = sat_weight((cmd == CMD_ADD_B ? longint'(bias[o]) : 0) + v);
               expect_result(0, 0, 1, ST_OK);
            end
         end
         CMD_FWD: begin
            if (i >= n_in) expect_result(0, 0, 1, ST_BAD_IDX);
            else begin
               x_cache[row][i] = v;
               x_written[row][i] = 1'b1;
               if (row_end) begin
                  cache_valid = 1'b1;
                  for (int a = 0; a < n_out; a++) begin
                     acc = longint'(bias[a]) * 4096;
                     for (int c = 0; c < n_in; c++)
                        acc += longint'(weight[a][c]) * x_cache[row][c];
                     expect_result(round_q12(acc), a, a + 1 == n_out, ST_OK);
                  end
               end
            end
         end
         CMD_BWD: begin
            if (!cache_valid) expect_result(0, 0, 1, ST_NO_CACHE);
            else if (!b_ok) expect_result(0, 0, 1, ST_BAD_IDX);
            else begin
               grad_buf[o] = v;
               grad_written[o] = 1'b1;
               if (row_end) begin
                  for (int a = 0; a < n_out; a++) begin
                     g = grad_buf[a];
                     for (int c = 0; c < n_in; c++) begin
                        v = round_q12(longint'(g) * x_cache[row][c]);
                        weight_grad[a][c] = (row == 0) ? v
                                          : sat_word(longint'(weight_grad[a][c]) + v);
                     end
                     bias_grad[a] = (row == 0) ? g : sat_word(longint'(bias_grad[a]) + g);
                  end
                  for (int c = 0; c < n_in; c++) begin
                     acc = 0;
                     for (int a = 0; a < n_out; a++)
                        acc += longint'(grad_buf[a]) * weight[a][c];
                     expect_result(round_q12(acc), c, c + 1 == n_in, ST_OK);
                  end
               end
            end
         end
         CMD_RD_W: begin
            if (!w_ok) expect_result(0, 0, 1, ST_BAD_IDX);
            else expect_result(weight[o][i], i, 1, ST_OK);
         end
         CMD_RD_B: begin
            if (!b_ok) expect_result(0, 0, 1, ST_BAD_IDX);
            else expect_result(bias[o], o, 1, ST_OK);
         end
         CMD_RD_DW: begin
            if (!cache_valid) expect_result(0, 0, 1, ST_NO_CACHE);
            else if (!w_ok) expect_result(0, 0, 1, ST_BAD_IDX);
            else expect_result(weight_grad[o][i], i, 1, ST_OK);
         end
         CMD_RD_DB: begin
            if (!cache_valid) expect_result(0, 0, 1, ST_NO_CACHE);
            else if (!b_ok) expect_result(0, 0, 1, ST_BAD_IDX);
            else expect_result(bias_grad[o], o, 1, ST_OK);
         end
         CMD_ZERO, CMD_CLEAR: begin
            foreach (weight_grad[a, c]) weight_grad[a][c] = 0;
            foreach (bias_grad[a]) bias_grad[a] = 0;
            if (cmd == CMD_CLEAR) cache_valid = 1'b0;
            expect_result(0, 0, 1, ST_OK);
         end
         default: expect_result(0, 0, 1, ST_BAD_IDX);
      endcase
   endtask

   // one command beat; the expectation is formed at the accepting edge
   task automatic send_item(logic [3:0] cmd, int row, int o, int i, logic [15:0] v, bit row_end);
      int gap;
      gap = no_gaps ? 0 : $urandom_range(0, 3);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tlast <= row_end;
      req_tdata <= {v, i[5:0], o[5:0], row[3:0]};
      do @(posedge clock); while (!req_tready);
      predict_layer(cmd, row, o, i, v, row_end);
   endtask

   task automatic wait_idle();
      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (IDLE_WAIT) @(posedge clock);
   endtask

   task automatic csr_access(logic reg_index, bit wr, logic [31:0] data);
      csr_psel <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite <= wr;
      csr_paddr <= {reg_index, 2'b00};
      csr_pwdata <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      if (!wr && csr_prdata[6:0] !== data[6:0]) begin
         mismatches++;
         if (mismatches <= 10)
            $display("csr read %0d: expected %0d got %0d", reg_index, data[6:0], csr_prdata);
      end
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
   endtask

   task automatic set_counts(logic [6:0] n_in, logic [6:0] n_out);
      wait_idle();
      csr_access(REG_INPUT_COUNT, 1'b1, n_in);
      csr_access(REG_OUTPUT_COUNT, 1'b1, n_out);
      input_count_reg = n_in;
      output_count_reg = n_out;
      csr_access(REG_INPUT_COUNT, 1'b0, n_in);
      csr_access(REG_OUTPUT_COUNT, 1'b0, n_out);
   endtask

   function automatic logic [15:0] pick_value();
      case ($urandom_range(0, 7))
         0: return 16'h8000;
         1: return 16'h7fff;
         default: return $urandom_range(0, 65535);
      endcase
   endfunction

   function automatic int pick_index(int n);
      return ($urandom_range(0, 9) == 0) ? $urandom_range(0, 63) : $urandom_range(0, n - 1);
   endfunction

   task automatic forward_row(int row);
      int n_in;
      n_in = eff_count(input_count_reg);
      for (int i = 0; i < n_in; i++)
         send_item(CMD_FWD, row, $urandom_range(0, 63), i, pick_value(), i == n_in - 1);
   endtask

   task automatic backward_row(int row);
      int n_out;
      n_out = eff_count(output_count_reg);
      for (int o = 0; o < n_out; o++)
         send_item(CMD_BWD, row, o, $urandom_range(0, 63), pick_value(), o == n_out - 1);
   endtask

   // receiver: random stalls, plus a long hold when requested; checks every beat
   always @(posedge clock) begin
      layer_result_t want;
      if (rsp_tvalid && rsp_tready) begin
         if (pending_results.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected result beat %h", rsp_tdata);
         end else begin
            want = pending_results.pop_front();
            if (rsp_tdata[31:0] !== want.value || rsp_tdata[37:32] !== want.pos ||
                rsp_tlast !== want.last || rsp_tuser !== want.status) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("result: expected val %h pos %0d last %b st %0d, got %h %0d %b %0d",
                           want.value, want.pos, want.last, want.status, rsp_tdata[31:0],
                           rsp_tdata[37:32], rsp_tlast, rsp_tuser);
            end
         end
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (hold_cycles > 0) begin
         hold_cycles--;
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else if (rsp_tvalid && rsp_tready && !no_gaps) begin
         stall_left = $urandom_range(0, 3);
         rsp_tready <= (stall_left == 0);
      end else begin
         rsp_tready <= 1'b1;
      end
   end

   task automatic test_parameter_access();
      no_gaps = 1'b0;
      send_item(CMD_RD_DW, 0, 0, 0, 16'h0, 1'b1);      // no forward row cached yet
      send_item(CMD_BWD, 0, 0, 0, 16'h1000, 1'b1);
      send_item(CMD_RD_DB, 0, 0, 0, 16'h0, 1'b0);
      send_item(CMD_WR_W, 0, 63, 63, 16'h7fff, 1'b0);
      send_item(CMD_ADD_W, 0, 63, 63, 16'h7fff, 1'b0);  // saturates high
      send_item(CMD_RD_W, 0, 63, 63, 16'h0, 1'b0);
      send_item(CMD_WR_B, 0, 63, 0, 16'h8000, 1'b0);
      send_item(CMD_ADD_B, 0, 63, 0, 16'h8000, 1'b0);   // saturates low
      send_item(CMD_RD_B, 0, 63, 0, 16'h0, 1'b0);
      send_item(CMD_UNUSED, 0, 0, 0, 16'h0, 1'b0);
      send_item(CMD_ZERO, 0, 0, 0, 16'h0, 1'b0);
      send_item(CMD_CLEAR, 0, 0, 0, 16'h0, 1'b0);
   endtask

   task automatic test_forward_backward();
      set_counts(7'd2, 7'd2);
      send_item(CMD_WR_W, 0, 2, 0, 16'h1000, 1'b0);     // row out of range
      send_item(CMD_WR_W, 0, 0, 2, 16'h1000, 1'b0);     // column out of range
      send_item(CMD_WR_W, 0, 1, 1, 16'h7fff, 1'b0);
      send_item(CMD_FWD, 15, 0, 5, 16'h1000, 1'b1);     // bad index, row end dropped
      send_item(CMD_FWD, 15, 0, 0, 16'h7fff, 1'b0);
      send_item(CMD_FWD, 15, 0, 1, 16'h8000, 1'b1);
      send_item(CMD_FWD, 0, 0, 0, 16'h1000, 1'b0);
      send_item(CMD_FWD, 0, 0, 1, 16'hf000, 1'b1);
      backward_row(0);
      backward_row(15);                                 // accumulates
      send_item(CMD_RD_DW, 0, 1, 1, 16'h0, 1'b0);
      send_item(CMD_RD_DB, 0, 1, 0, 16'h0, 1'b0);
   endtask

   task automatic test_count_extremes();
      set_counts(7'd127, 7'd0);                         // clamps to 64 by 1
      forward_row(3);
      backward_row(3);
      send_item(CMD_RD_DW, 0, 0, 63, 16'h0, 1'b0);
      set_counts(7'd1, 7'd64);
      forward_row(4);
      send_item(CMD_RD_B, 0, 63, 0, 16'h0, 1'b0);
   endtask

   task automatic test_output_backpressure();
      wait_idle();
      @(posedge clock);
      hold_cycles = 300;
      no_gaps = 1'b1;
      for (int k = 0; k < 16; k++) send_item(CMD_WR_B, 0, 0, 0, pick_value(), 1'b0);
      no_gaps = 1'b0;
   endtask

   task automatic random_phase(logic [6:0] n_in_reg, logic [6:0] n_out_reg, int count);
      int sent, n_in, n_out, row, o, i, ready_row;
      logic [3:0] cmd;
      bit row_end;
      set_counts(n_in_reg, n_out_reg);
      n_in = eff_count(n_in_reg);
      n_out = eff_count(n_out_reg);
      sent = 0;
      while (sent < count) begin
         no_gaps = ($urandom_range(0, 5) == 0);
         case ($urandom_range(0, 9))
            0, 1, 2: begin
               forward_row($urandom_range(0, 15));
               sent += n_in;
            end
            3, 4: begin
               ready_row = -1;
               if (cache_valid)
                  for (int r = 0; r < 16; r++) if (row_complete(CMD_BWD, r, 0, 0)) ready_row = r;
               row = $urandom_range(0, 15);
               if (cache_valid && ready_row < 0) begin
                  forward_row(row);
                  ready_row = row;
               end
               if (ready_row >= 0 && $urandom_range(0, 3) != 0) row = ready_row;
               foreach (grad_written[a]) grad_written[a] = 1'b0;
               if (cache_valid) backward_row(row);
               else send_item(CMD_BWD, row, 0, 0, pick_value(), 1'b1);
               sent += n_out;
            end
            default: begin
               cmd = ($urandom_range(0, 4) == 0) ? $urandom_range(10, 15) : $urandom_range(0, 9);
               row = $urandom_range(0, 15);
               o = pick_index(n_out);
               i = pick_index(n_in);
               row_end = $urandom_range(0, 1);
               if (!row_complete(cmd, row, o, i)) row_end = 1'b0;
               send_item(cmd, row, o, i, pick_value(), row_end);
               sent++;
            end
         endcase
      end
      no_gaps = 1'b0;
   endtask

   initial begin
      reset <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata <= '0;
      req_tuser <= '0;
      req_tlast <= 1'b0;
      csr_psel <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite <= 1'b0;
      csr_paddr <= '0;
      csr_pwdata <= '0;
      mismatches = 0;
      hold_cycles = 0;
      stall_left = 0;
      no_gaps = 1'b0;
      foreach (weight[a, c]) begin
         weight[a][c] = 0;
         weight_grad[a][c] = 0;
      end
      foreach (bias[a]) begin
         bias[a] = 0;
         bias_grad[a] = 0;
         grad_written[a] = 1'b0;
      end
      foreach (x_written[r, c]) x_written[r][c] = 1'b0;
      cache_valid = 1'b0;
      input_count_reg = 7'd64;
      output_count_reg = 7'd64;
      repeat (5) @(posedge clock);
      reset <= 1'b0;

      test_parameter_access();
      test_forward_backward();
      test_count_extremes();
      test_output_backpressure();
      random_phase(7'd4, 7'd3, 60);
      random_phase(7'd0, 7'd5, 40);
      random_phase(7'd7, 7'd1, 50);

      req_tvalid <= 1'b0;
      while (pending_results.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule
